>>> rtl/smart_card_atr_parser_defines.svh
// Assertion macros for the smart card ATR parser.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef SMART_CARD_ATR_PARSER_DEFINES_SVH
`define SMART_CARD_ATR_PARSER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define SCA_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("ATR parser assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SCA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("ATR parser assertion failed");

`else

`define SCA_ASSERT_NOW(lbl, ant, cons)
`define SCA_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

>>> rtl/sc_atr_pkg.sv
// Shared types and codes for the smart card ATR parser.
// No dependencies; imported by sc_atr_classify and smart_card_atr_parser.
package sc_atr_pkg;

  // Input transaction payload
  typedef struct packed {
    logic       mode;
    logic [7:0] char_value;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] kind;
    logic [2:0] group_index;
    logic [3:0] hist_index;
    logic       reverse_conv;
    logic       atr_done;
    logic [1:0] status;
  } out_item_t;

  // Input mode codes
  localparam logic MODE_CHAR    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Character kinds
  localparam logic [2:0] KIND_TS   = 3'd0;
  localparam logic [2:0] KIND_T0   = 3'd1;
  localparam logic [2:0] KIND_TA   = 3'd2;
  localparam logic [2:0] KIND_TB   = 3'd3;
  localparam logic [2:0] KIND_TC   = 3'd4;
  localparam logic [2:0] KIND_TD   = 3'd5;
  localparam logic [2:0] KIND_HIST = 3'd6;
  localparam logic [2:0] KIND_TCK  = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TS    = 2'd1;
  localparam logic [1:0] ST_AFTER_END = 2'd2;
  localparam logic [1:0] ST_TOO_MANY  = 2'd3;

  // TS convention characters
  localparam logic [7:0] TS_DIRECT      = 8'h3B;
  localparam logic [7:0] TS_INVERSE     = 8'h03;
  localparam logic [7:0] TS_INVERSE_OUT = 8'h3F;

endpackage

>>> rtl/smart_card_atr_parser.sv
// Smart card ATR parser top level: input register, classifier, result register.
// Depends on sc_atr_pkg, sc_atr_classify and smart_card_atr_parser_defines.svh.
//
// Usage:
//   Send each received ATR character on in_data with mode clear; send a
//   transaction with mode set to restart parsing for a new ATR. Every input
//   transaction yields exactly one result on out_data, in order.
//   Both channels are valid/ready; a transaction moves when both are high.
//   Latency is two register stages, the input register and the result
//   register; out_valid rises once the accepted transaction is loaded into
//   the result register. Throughput is one transaction per cycle while the
//   receiver does not stall: the input register feeds the classifier, which
//   updates the parse state and loads the result register in the same cycle.
//   When the receiver stalls, the result register holds its transaction and
//   the input register takes one more; in_ready drops only when both are
//   full and out_ready is low.
//   Synchronous reset clears the valid flags of both registers and returns
//   the parser to waiting for TS with direct convention.
`include "smart_card_atr_parser_defines.svh"

module smart_card_atr_parser #(
  parameter int MAX_GROUPS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sc_atr_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sc_atr_pkg::out_item_t out_data
);
  import sc_atr_pkg::*;

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      advance;
  logic      fire;

  // Result register can take a new transaction when empty or draining
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  sc_atr_classify #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data_r),
    .result(result)
  );

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SCA_ASSERT_NEXT(a_fire_fills_out, fire, out_valid_r)
  `SCA_ASSERT_NEXT(a_in_hold_stall, in_valid_r && !advance, in_valid_r && $stable(in_data_r))
  `SCA_ASSERT_NOW(a_bad_ts_fields, out_valid_r && out_data_r.status == ST_BAD_TS,
    out_data_r.kind == KIND_TS && !out_data_r.reverse_conv && !out_data_r.atr_done)
  `SCA_ASSERT_NOW(a_hist_ok, out_valid_r && out_data_r.kind == KIND_HIST,
    out_data_r.status == ST_OK && out_data_r.group_index == 3'd0)

endmodule

>>> rtl/sc_atr_classify.sv
// ATR character classifier: parse state and next-state logic for one character.
// Depends on sc_atr_pkg. State advances only on the fire strobe from the top level.
module sc_atr_classify #(
  parameter int MAX_GROUPS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  sc_atr_pkg::in_item_t  item,
  output sc_atr_pkg::out_item_t result
);
  import sc_atr_pkg::*;

  localparam int GW = $clog2(MAX_GROUPS);
  localparam logic [GW-1:0] GC_LAST = GW'(MAX_GROUPS - 1);

  typedef enum logic [3:0] {
    PH_TS, PH_T0, PH_TA, PH_TB, PH_TC, PH_TD, PH_HIST, PH_TCK, PH_DONE
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [7:0]    ind_r, ind_nxt;
  logic [GW-1:0] gc_r, gc_nxt;
  logic [3:0]    he_r, he_nxt;
  logic [3:0]    hc_r, hc_nxt;
  logic          tck_r, tck_nxt;
  logic          rev_r, rev_nxt;

  logic [7:0]    c;
  logic [2:0]    from;
  logic          walk;

  // Pick the next interface byte announced at or after 'from', else the tail
  function automatic phase_t next_phase(input logic [7:0] ind, input logic [2:0] frm,
                                        input logic [3:0] hc, input logic [3:0] he,
                                        input logic tck);
    logic       found;
    logic [1:0] sel;
    phase_t     ph;
    found = 1'b0;
    sel   = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (!found && (3'(k) >= frm) && ind[4+k]) begin
        found = 1'b1;
        sel   = 2'(k);
      end
    end
    if (found) begin
      unique case (sel)
        2'd0: ph = PH_TA;
        2'd1: ph = PH_TB;
        2'd2: ph = PH_TC;
        2'd3: ph = PH_TD;
      endcase
    end else if (hc < he) begin
      ph = PH_HIST;
    end else if (tck) begin
      ph = PH_TCK;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  assign c = item.char_value;

  // Classify the character and work out the next parse state
  always_comb begin
    phase_nxt = phase_r;
    ind_nxt   = ind_r;
    gc_nxt    = gc_r;
    he_nxt    = he_r;
    hc_nxt    = hc_r;
    tck_nxt   = tck_r;
    rev_nxt   = rev_r;
    from      = 3'd4;
    walk      = 1'b0;
    result    = '0;
    result.byte_out = c;
    result.kind     = KIND_TS;
    result.status   = ST_OK;

    if (item.mode == MODE_RESTART) begin
      phase_nxt = PH_TS;
      ind_nxt   = '0;
      gc_nxt    = '0;
      he_nxt    = '0;
      hc_nxt    = '0;
      tck_nxt   = 1'b0;
      rev_nxt   = 1'b0;
      result    = '0;
    end else begin
      unique case (phase_r)
        PH_TS: begin
          if (c == TS_DIRECT) begin
            rev_nxt   = 1'b0;
            phase_nxt = PH_T0;
          end else if (c == TS_INVERSE) begin
            rev_nxt   = 1'b1;
            result.byte_out = TS_INVERSE_OUT;
            phase_nxt = PH_T0;
          end else begin
            rev_nxt = 1'b0;
            result.status = ST_BAD_TS;
          end
        end
        PH_T0: begin
          result.kind = KIND_T0;
          ind_nxt = c;
          gc_nxt  = '0;
          he_nxt  = c[3:0];
          hc_nxt  = '0;
          tck_nxt = 1'b0;
          from    = 3'd0;
          walk    = 1'b1;
        end
        PH_TA: begin
          result.kind        = KIND_TA;
          result.group_index = 3'(gc_r);
          from = 3'd1;
          walk = 1'b1;
        end
        PH_TB: begin
          result.kind        = KIND_TB;
          result.group_index = 3'(gc_r);
          from = 3'd2;
          walk = 1'b1;
        end
        PH_TC: begin
          result.kind        = KIND_TC;
          result.group_index = 3'(gc_r);
          from = 3'd3;
          walk = 1'b1;
        end
        PH_TD: begin
          result.kind        = KIND_TD;
          result.group_index = 3'(gc_r);
          ind_nxt = c;
          if (c[3:0] != 4'd0) begin
            tck_nxt = 1'b1;
          end
          // Last group: drop any further interface bytes
          if (gc_r == GC_LAST) begin
            if (c[7:4] != 4'd0) begin
              result.status = ST_TOO_MANY;
            end
            ind_nxt = {4'd0, c[3:0]};
          end else begin
            gc_nxt = gc_r + 1'b1;
          end
          from = 3'd0;
          walk = 1'b1;
        end
        PH_HIST: begin
          result.kind       = KIND_HIST;
          result.hist_index = hc_r;
          hc_nxt = hc_r + 4'd1;
          from   = 3'd4;
          walk   = 1'b1;
        end
        PH_TCK: begin
          result.kind     = KIND_TCK;
          result.atr_done = 1'b1;
          phase_nxt       = PH_DONE;
        end
        default: begin
          result.status = ST_AFTER_END;
          phase_nxt     = PH_DONE;
        end
      endcase

      if (walk) begin
        phase_nxt = next_phase(ind_nxt, from, hc_nxt, he_nxt, tck_nxt);
        result.atr_done = (phase_nxt == PH_DONE);
      end
      result.reverse_conv = rev_nxt;
    end
  end

  // Hold parse state; advance on each fired transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TS;
      ind_r   <= '0;
      gc_r    <= '0;
      he_r    <= '0;
      hc_r    <= '0;
      tck_r   <= 1'b0;
      rev_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      ind_r   <= ind_nxt;
      gc_r    <= gc_nxt;
      he_r    <= he_nxt;
      hc_r    <= hc_nxt;
      tck_r   <= tck_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule
